/* sv/bsc_pkg.sv */
// Shared constants, register indexes and helpers for the barometric compensation block.
// No dependencies.
`default_nettype none
package bsc_pkg;

  localparam int DIV_W   = 32;               // divider operand width
  localparam int DIV_LAT = DIV_W;            // one quotient bit per stage
  localparam int NSTG    = 19 + 2 * DIV_LAT; // total register stages, input to output

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 64;

  typedef enum logic [CFG_AW-1:0] {
    REG_CAL_A   = 3'd0,
    REG_CAL_B   = 3'd1,
    REG_CAL_C   = 3'd2,
    REG_OSS     = 3'd3,
    REG_SEA_OFS = 3'd4
  } cfg_reg_t;

  localparam logic [1:0]  OSS_RST = 2'd1;
  localparam logic [15:0] SEA_RST = 16'd8400;

  // signed divide by 2**k, truncating toward zero
  function automatic logic signed [31:0] sdiv_p2(input logic signed [31:0] v, input int k);
    logic [31:0] bias;
    begin
      bias = (32'd1 << k) - 32'd1;
      sdiv_p2 = $signed(v + (v[31] ? bias : 32'd0)) >>> k;
    end
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    begin
      if (v > 32'sd32767) sat16 = 16'sh7fff;
      else if (v < -32'sd32768) sat16 = 16'sh8000;
      else sat16 = v[15:0];
    end
  endfunction

  typedef struct packed {
    logic signed [31:0] x1;
    logic               neg;
    logic               dvz;
    logic [18:0]        up;
  } sidea_t;

  typedef struct packed {
    logic signed [15:0] tc;
    logic signed [15:0] tf;
    logic               flt;
  } temp_t;

  typedef struct packed {
    logic  big;
    logic  b4z;
    temp_t tmp;
  } sideb_t;

endpackage
`default_nettype wire

/* sv/bsc_udiv.sv */
// Pipelined unsigned 32/32 restoring divider, one quotient bit per stage.
// Depends on bsc_pkg. Division by zero gives all ones; callers mask it.
`default_nettype none
module bsc_udiv (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [bsc_pkg::DIV_W-1:0]    num,
  input  wire logic [bsc_pkg::DIV_W-1:0]    den,
  output logic      [bsc_pkg::DIV_W-1:0]    quo
);
  localparam int W = bsc_pkg::DIV_W;

  logic [W-1:0] rem_r [0:W-1];
  logic [W-1:0] num_r [0:W-1];
  logic [W-1:0] den_r [0:W-1];
  logic [W-1:0] quo_r [0:W-1];

  genvar i;
  generate
    for (i = 0; i < W; i++) begin : g_stg
      logic [W-1:0] rem_p, num_p, den_p, quo_p;
      logic [W:0]   trial;
      logic         ge;
      if (i == 0) begin : g_first
        assign rem_p = '0;
        assign num_p = num;
        assign den_p = den;
        assign quo_p = '0;
      end else begin : g_next
        assign rem_p = rem_r[i-1];
        assign num_p = num_r[i-1];
        assign den_p = den_r[i-1];
        assign quo_p = quo_r[i-1];
      end
      assign trial = {rem_p, num_p[W-1]};
      assign ge    = trial >= {1'b0, den_p};
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= ge ? W'(trial - {1'b0, den_p}) : trial[W-1:0];
          num_r[i] <= {num_p[W-2:0], 1'b0};
          den_r[i] <= den_p;
          quo_r[i] <= {quo_p[W-2:0], ge};
        end
      end
    end
  endgenerate

  assign quo = quo_r[W-1];
endmodule
`default_nettype wire

/* sv/baro_sensor_compensation.sv */
// Top level: integer temperature/pressure compensation for a barometric sensor.
// Depends on bsc_pkg and bsc_udiv.
//
// Usage:
//  - Input stream in_*: one item per raw temperature/pressure pair.
//  - Output stream out_*: one result item per input item, same order.
//  - Config port cfg_*: write-only calibration registers, written while idle.
// Pipeline: 19 arithmetic stages plus two 32-stage dividers, one for the
// temperature term and one for the pressure quotient.
// Throughput: one item per cycle while out_tready does not stall the output;
// the dividers retire one quotient bit per stage, so each holds 32 items in flight.
// Stall: all stages move together; when a result waits in the output register
// and out_tready is low, in_tready drops and every stage holds its item.
// Reset (rst_n low, synchronous): all valid bits clear, calibration resets to
// zero, oversampling to 1 and sea-level offset to 8400 Pa.
// A zero divisor gives a zero quotient and raises div_fault (out_tuser).
`default_nettype none
module baro_sensor_compensation (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // raw_temp[15:0], raw_press[34:16], zero pad
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [95:0]      out_tdata,  // temp_tenth_c, temp_tenth_f, press_pa, press_sea
  output logic [0:0]       out_tuser,  // div_fault
  input  wire logic        cfg_we,
  input  wire logic [bsc_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [bsc_pkg::CFG_DW-1:0] cfg_wdata
);
  localparam int NSTG = bsc_pkg::NSTG;
  localparam int DL   = bsc_pkg::DIV_LAT;

  // ---------------- configuration ----------------
  logic [47:0] cal_a_r, cal_b_r;
  logic [63:0] cal_c_r;
  logic [1:0]  oss_r;
  logic [15:0] sea_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_a_r <= '0;
      cal_b_r <= '0;
      cal_c_r <= '0;
      oss_r   <= bsc_pkg::OSS_RST;
      sea_r   <= bsc_pkg::SEA_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bsc_pkg::REG_CAL_A:   cal_a_r <= cfg_wdata[47:0];
        bsc_pkg::REG_CAL_B:   cal_b_r <= cfg_wdata[47:0];
        bsc_pkg::REG_CAL_C:   cal_c_r <= cfg_wdata;
        bsc_pkg::REG_OSS:     oss_r   <= cfg_wdata[1:0];
        bsc_pkg::REG_SEA_OFS: sea_r   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // coefficients, sign- or zero-extended to 32 bits
  logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [31:0]        ac4, ac5, ac6;
  assign ac1 = 32'(signed'(cal_a_r[47:32]));
  assign ac2 = 32'(signed'(cal_a_r[31:16]));
  assign ac3 = 32'(signed'(cal_a_r[15:0]));
  assign ac4 = {16'd0, cal_b_r[47:32]};
  assign ac5 = {16'd0, cal_b_r[31:16]};
  assign ac6 = {16'd0, cal_b_r[15:0]};
  assign b1  = 32'(signed'(cal_c_r[63:48]));
  assign b2  = 32'(signed'(cal_c_r[47:32]));
  assign mc  = 32'(signed'(cal_c_r[31:16]));
  assign md  = 32'(signed'(cal_c_r[15:0]));

  // ---------------- flow control ----------------
  // Single advance for the whole pipe; the last stage is the output register.
  logic            adv;
  logic [NSTG-1:0] vld_r;

  assign adv       = !vld_r[NSTG-1] || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[NSTG-2:0], in_tvalid};
  end

  // ---------------- temperature front ----------------
  logic signed [17:0] t1_d_r;
  logic [18:0]        t1_up_r, t2_up_r;
  logic signed [34:0] t2_prod_r;
  bsc_pkg::sidea_t    t3_r;
  logic [31:0]        t3_anum_r, t3_aden_r;

  logic signed [31:0] x1_a, dv_a, num_a;
  assign x1_a  = $signed(t2_prod_r[31:0]) >>> 15;
  assign dv_a  = x1_a + md;
  assign num_a = mc <<< 11;

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_d_r    <= $signed({2'b00, in_tdata[15:0]}) - $signed({2'b00, ac6[15:0]});
      t1_up_r   <= in_tdata[34:16];
      t2_prod_r <= t1_d_r * $signed({1'b0, ac5[15:0]});
      t2_up_r   <= t1_up_r;
      t3_r.x1   <= x1_a;
      t3_r.neg  <= num_a[31] ^ dv_a[31];
      t3_r.dvz  <= dv_a == 32'sd0;
      t3_r.up   <= t2_up_r;
      t3_anum_r <= num_a[31] ? 32'(-num_a) : num_a;
      t3_aden_r <= dv_a[31] ? 32'(-dv_a) : dv_a;
    end
  end

  // temperature divider and its side data
  logic [31:0]     quo_a;
  bsc_pkg::sidea_t dla_r [0:DL-1];

  bsc_udiv u_div_t (
    .clk (clk),
    .en  (adv),
    .num (t3_anum_r),
    .den (t3_aden_r),
    .quo (quo_a)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dla_r[0] <= t3_r;
      for (int k = 1; k < DL; k++) dla_r[k] <= dla_r[k-1];
    end
  end

  // ---------------- temperature back, pressure terms ----------------
  bsc_pkg::sidea_t sa;
  logic signed [31:0] x2_a;
  assign sa   = dla_r[DL-1];
  assign x2_a = sa.dvz ? 32'sd0 : (sa.neg ? 32'(-quo_a) : quo_a);

  logic signed [31:0] t4_b5_r;
  logic               t4_flt_r;
  logic [18:0]        up4_r, up5_r, up6_r, up7_r, up8_r, up9_r, up10_r, up11_r;
  logic signed [31:0] t5_t_r, t5_b6_r;
  logic signed [31:0] t6_sqp_r, t6_tp_r, t6_b6_r;
  logic signed [15:0] t6_tc_r, t7_tc_r, t8_tc_r;
  logic               t5_flt_r, t6_flt_r, t7_flt_r, t8_flt_r;
  logic signed [31:0] t7_sq_r, t7_b6_r;
  logic [31:0]        t7_atp_r;
  logic               t7_tneg_r, t8_tneg_r;
  logic signed [31:0] t8_p1_r, t8_p2_r, t8_p3_r, t8_p4_r;
  logic [31:0]        t8_dq_r;
  logic [63:0]        dq_full;
  logic signed [31:0] t9_x1_r, t9_x2_r, t9_x1b_r, t9_x2b_r;
  logic signed [31:0] tq, tf32;
  bsc_pkg::temp_t     t9_tmp_r, t10_tmp_r, t11_tmp_r, t12_tmp_r, t13_tmp_r, t14_tmp_r;
  logic signed [31:0] t10_x3_r, t10_s_r;
  logic signed [31:0] t11_b3_r, t11_x3b_r;
  logic signed [31:0] b3_sum, b3_shf;
  logic [31:0]        t12_b4p_r, t12_t7_r;
  logic [31:0]        t13_b4_r, t13_b7_r;
  logic [31:0]        t14_num_r, t14_den_r;
  logic               t14_big_r, t14_b4z_r;

  assign dq_full = t7_atp_r * 64'h0000_0000_CCCC_CCCD;
  assign tq      = t8_tneg_r ? 32'(-t8_dq_r) : t8_dq_r;
  assign tf32    = 32'sd320 + tq;
  assign b3_sum  = (ac1 <<< 2) + t10_x3_r;
  assign b3_shf  = b3_sum <<< oss_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      // T4
      t4_b5_r   <= sa.x1 + x2_a;
      t4_flt_r  <= sa.dvz;
      up4_r     <= sa.up;
      // T5
      t5_t_r    <= (t4_b5_r + 32'sd8) >>> 4;
      t5_b6_r   <= t4_b5_r - 32'sd4000;
      t5_flt_r  <= t4_flt_r;
      up5_r     <= up4_r;
      // T6
      t6_sqp_r  <= 32'(t5_b6_r * t5_b6_r);
      t6_tp_r   <= 32'(t5_t_r * 32'sd18);
      t6_tc_r   <= bsc_pkg::sat16(t5_t_r);
      t6_b6_r   <= t5_b6_r;
      t6_flt_r  <= t5_flt_r;
      up6_r     <= up5_r;
      // T7
      t7_sq_r   <= bsc_pkg::sdiv_p2(t6_sqp_r, 12);
      t7_atp_r  <= t6_tp_r[31] ? 32'(-t6_tp_r) : t6_tp_r;
      t7_tneg_r <= t6_tp_r[31];
      t7_b6_r   <= t6_b6_r;
      t7_tc_r   <= t6_tc_r;
      t7_flt_r  <= t6_flt_r;
      up7_r     <= up6_r;
      // T8: 16x32 products and the divide-by-ten reciprocal
      t8_p1_r   <= 32'(b2 * t7_sq_r);
      t8_p2_r   <= 32'(ac2 * t7_b6_r);
      t8_p3_r   <= 32'(ac3 * t7_b6_r);
      t8_p4_r   <= 32'(b1 * t7_sq_r);
      t8_dq_r   <= 32'(dq_full >> 35);
      t8_tneg_r <= t7_tneg_r;
      t8_tc_r   <= t7_tc_r;
      t8_flt_r  <= t7_flt_r;
      up8_r     <= up7_r;
      // T9
      t9_x1_r   <= bsc_pkg::sdiv_p2(t8_p1_r, 11);
      t9_x2_r   <= bsc_pkg::sdiv_p2(t8_p2_r, 11);
      t9_x1b_r  <= bsc_pkg::sdiv_p2(t8_p3_r, 13);
      t9_x2b_r  <= bsc_pkg::sdiv_p2(t8_p4_r, 16);
      t9_tmp_r  <= '{tc: t8_tc_r, tf: bsc_pkg::sat16(tf32), flt: t8_flt_r};
      up9_r     <= up8_r;
      // T10
      t10_x3_r  <= t9_x1_r + t9_x2_r;
      t10_s_r   <= t9_x1b_r + t9_x2b_r + 32'sd2;
      t10_tmp_r <= t9_tmp_r;
      up10_r    <= up9_r;
      // T11
      t11_b3_r  <= bsc_pkg::sdiv_p2(b3_shf + 32'sd2, 2);
      t11_x3b_r <= bsc_pkg::sdiv_p2(t10_s_r, 2);
      t11_tmp_r <= t10_tmp_r;
      up11_r    <= up10_r;
      // T12
      t12_b4p_r <= 32'(ac4 * 32'(t11_x3b_r + 32'sd32768));
      t12_t7_r  <= 32'({13'd0, up11_r} - t11_b3_r);
      t12_tmp_r <= t11_tmp_r;
      // T13
      t13_b4_r  <= t12_b4p_r >> 15;
      t13_b7_r  <= 32'(t12_t7_r * (32'd50000 >> oss_r));
      t13_tmp_r <= t12_tmp_r;
      // T14: two-branch quotient, small b7 is doubled before the divide
      t14_big_r <= t13_b7_r[31];
      t14_num_r <= t13_b7_r[31] ? t13_b7_r : {t13_b7_r[30:0], 1'b0};
      t14_den_r <= t13_b4_r;
      t14_b4z_r <= t13_b4_r == 32'd0;
      t14_tmp_r <= t13_tmp_r;
    end
  end

  // ---------------- pressure divider ----------------
  logic [31:0]     quo_b;
  bsc_pkg::sideb_t dlb_r [0:DL-1];

  bsc_udiv u_div_p (
    .clk (clk),
    .en  (adv),
    .num (t14_num_r),
    .den (t14_den_r),
    .quo (quo_b)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dlb_r[0] <= '{big: t14_big_r, b4z: t14_b4z_r, tmp: t14_tmp_r};
      for (int k = 1; k < DL; k++) dlb_r[k] <= dlb_r[k-1];
    end
  end

  // ---------------- pressure correction ----------------
  bsc_pkg::sideb_t    sb;
  logic signed [31:0] t15_p_r, t16_p_r, t17_p_r, t18_p_r;
  bsc_pkg::temp_t     t15_tmp_r, t16_tmp_r, t17_tmp_r, t18_tmp_r;
  logic signed [31:0] xd, t16_pp_r, t16_m2_r, t17_x1_r, t17_x2_r, t18_s_r;
  logic signed [31:0] p_fin;
  logic signed [15:0] o_tc_r, o_tf_r;
  logic signed [31:0] o_p_r, o_sea_r;
  logic               o_flt_r;

  assign sb    = dlb_r[DL-1];
  assign xd    = bsc_pkg::sdiv_p2(t15_p_r, 8);
  assign p_fin = t18_p_r + bsc_pkg::sdiv_p2(t18_s_r, 4);

  always_ff @(posedge clk) begin
    if (adv) begin
      // T15
      t15_p_r   <= sb.b4z ? 32'sd0 : (sb.big ? {quo_b[30:0], 1'b0} : quo_b);
      t15_tmp_r <= '{tc: sb.tmp.tc, tf: sb.tmp.tf, flt: sb.tmp.flt | sb.b4z};
      // T16
      t16_pp_r  <= 32'(xd * xd);
      t16_m2_r  <= 32'(-32'sd7357 * t15_p_r);
      t16_p_r   <= t15_p_r;
      t16_tmp_r <= t15_tmp_r;
      // T17
      t17_x1_r  <= 32'(t16_pp_r * 32'sd3038);
      t17_x2_r  <= bsc_pkg::sdiv_p2(t16_m2_r, 16);
      t17_p_r   <= t16_p_r;
      t17_tmp_r <= t16_tmp_r;
      // T18
      t18_s_r   <= bsc_pkg::sdiv_p2(t17_x1_r, 16) + t17_x2_r + 32'sd3791;
      t18_p_r   <= t17_p_r;
      t18_tmp_r <= t17_tmp_r;
      // output register
      o_p_r     <= p_fin;
      o_sea_r   <= p_fin + $signed({16'd0, sea_r});
      o_tc_r    <= t18_tmp_r.tc;
      o_tf_r    <= t18_tmp_r.tf;
      o_flt_r   <= t18_tmp_r.flt;
    end
  end

  assign out_tvalid = vld_r[NSTG-1];
  assign out_tdata  = {o_sea_r, o_p_r, o_tf_r, o_tc_r};
  assign out_tuser  = o_flt_r;

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for baro_sensor_compensation: raw temperature/pressure items
// are streamed in under several calibration settings and each result is compared with
// a built-in integer compensation predictor. Depends on bsc_pkg and the block RTL.
`timescale 1ns / 1ps
module tb_top;

  localparam int LAT = 83;
  localparam int WDOG_LIMIT = 4000;

  typedef struct packed {
    logic signed [15:0] tc;
    logic signed [15:0] tf;
    logic signed [31:0] pa;
    logic signed [31:0] sea;
    logic               flt;
  } comp_res_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [39:0] in_tdata;   // raw_temp[15:0], raw_press[34:16], zero pad
  logic out_tvalid;
  logic out_tready;
  logic [95:0] out_tdata;  // temp_tenth_c, temp_tenth_f, press_pa, press_sea
  logic [0:0] out_tuser;   // div_fault
  logic cfg_we;
  logic [bsc_pkg::CFG_AW-1:0] cfg_addr;
  logic [bsc_pkg::CFG_DW-1:0] cfg_wdata;

  baro_sensor_compensation u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // Predictor's copy of the calibration registers
  logic [47:0] cal_a, cal_b;
  logic [63:0] cal_c;
  logic [1:0]  oss;
  logic [15:0] sea_ofs;

  comp_res_t expected_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_faults = 0;
  int idle_cycles = 0;
  bit rx_quiet = 0;   // forces out_tready high, no stalls

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Signed division truncating toward zero, 32-bit wrap on the quotient.
  function automatic logic signed [31:0] tdiv(input logic signed [31:0] a, input int d);
    longint q;
    begin
      q = longint'(a) / d;
      tdiv = q[31:0];
    end
  endfunction

  // Integer compensation, all intermediates 32-bit two's complement.
  function automatic comp_res_t compensate(input logic [15:0] ut, input logic [18:0] up);
    comp_res_t r;
    logic signed [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic signed [31:0] x1, x2, x3, dv, b5, t, tf, b6, sq, b3, p;
    logic [31:0] b4, b7, q;
    begin
      ac1 = $signed(cal_a[47:32]); ac2 = $signed(cal_a[31:16]); ac3 = $signed(cal_a[15:0]);
      ac4 = {16'd0, cal_b[47:32]}; ac5 = {16'd0, cal_b[31:16]}; ac6 = {16'd0, cal_b[15:0]};
      b1 = $signed(cal_c[63:48]); b2 = $signed(cal_c[47:32]);
      mc = $signed(cal_c[31:16]); md = $signed(cal_c[15:0]);
      r.flt = 1'b0;
      x1 = (($signed({16'd0, ut}) - ac6) * ac5) >>> 15;
      dv = x1 + md;
      if (dv == 0) begin
        x2 = 0;
        r.flt = 1'b1;
      end else begin
        x2 = 32'((longint'(mc) * 2048) / longint'(dv));  // mc*2048 fits; quotient wraps
      end
      b5 = x1 + x2;
      t = (b5 + 8) >>> 4;
      tf = 32'sd320 + tdiv(t * 18, 10);
      b6 = b5 - 4000;
      sq = tdiv(b6 * b6, 4096);
      x1 = tdiv(b2 * sq, 2048);
      x2 = tdiv(ac2 * b6, 2048);
      x3 = x1 + x2;
      b3 = tdiv(((ac1 * 4 + x3) <<< oss) + 2, 4);
      x1 = tdiv(ac3 * b6, 8192);
      x2 = tdiv(b1 * sq, 65536);
      x3 = tdiv(x1 + x2 + 2, 4);
      b4 = (ac4 * (x3 + 32768)) >> 15;
      b7 = ($signed({13'd0, up}) - b3) * (32'd50000 >> oss);
      if (b4 == 0) begin
        q = 0;
        r.flt = 1'b1;
      end else if (b7 < 32'h8000_0000) begin
        q = (b7 * 2) / b4;
      end else begin
        q = (b7 / b4) * 2;
      end
      p = q;
      x1 = tdiv(p, 256) * tdiv(p, 256);
      x1 = tdiv(x1 * 3038, 65536);
      x2 = tdiv(-32'sd7357 * p, 65536);
      p = p + tdiv(x1 + x2 + 3791, 16);
      r.pa = p;
      r.sea = p + {16'd0, sea_ofs};
      r.tc = bsc_pkg::sat16(t);
      r.tf = bsc_pkg::sat16(tf);
      return r;
    end
  endfunction

  // Watchdog: cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, expected_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: random backpressure, compare each accepted result
  initial begin
    int stall;
    comp_res_t got, exp_r;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = rx_quiet ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk iff out_tvalid);
      got.tc = out_tdata[15:0];
      got.tf = out_tdata[31:16];
      got.pa = out_tdata[63:32];
      got.sea = out_tdata[95:64];
      got.flt = out_tuser[0];
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, got);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        n_checked++;
        if (exp_r.flt) n_faults++;
        if (got.tc !== exp_r.tc) begin
          $display("%0t: temp_tenth_c expected %0d actual %0d", $time, exp_r.tc, got.tc);
          errors++;
        end
        if (got.tf !== exp_r.tf) begin
          $display("%0t: temp_tenth_f expected %0d actual %0d", $time, exp_r.tf, got.tf);
          errors++;
        end
        if (got.pa !== exp_r.pa) begin
          $display("%0t: press_pa expected %0d actual %0d", $time, exp_r.pa, got.pa);
          errors++;
        end
        if (got.sea !== exp_r.sea) begin
          $display("%0t: press_sea expected %0d actual %0d", $time, exp_r.sea, got.sea);
          errors++;
        end
        if (got.flt !== exp_r.flt) begin
          $display("%0t: div_fault expected %0b actual %0b", $time, exp_r.flt, got.flt);
          errors++;
        end
      end
    end
  end

  // Send one raw pair; the expectation is queued at the accepting edge.
  // in_tvalid stays high afterwards; a gap or drain() lowers it.
  task automatic send_raw(input logic [15:0] ut, input logic [18:0] up, input bit gaps);
    int gap;
    begin
      gap = gaps ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata <= {5'd0, up, ut};
      @(posedge clk iff in_tready);
      expected_q.push_back(compensate(ut, up));
      n_sent++;
    end
  endtask

  task automatic drain();
    begin
      in_tvalid <= 1'b0;
      wait (expected_q.size() == 0);
      repeat (LAT + 10) @(posedge clk);
    end
  endtask

  task automatic write_reg(input bsc_pkg::cfg_reg_t idx, input logic [63:0] val);
    begin
      cfg_we <= 1'b1;
      cfg_addr <= idx;
      cfg_wdata <= val;
      @(posedge clk);
      cfg_we <= 1'b0;
      case (idx)
        bsc_pkg::REG_CAL_A:   cal_a = val[47:0];
        bsc_pkg::REG_CAL_B:   cal_b = val[47:0];
        bsc_pkg::REG_CAL_C:   cal_c = val;
        bsc_pkg::REG_OSS:     oss = val[1:0];
        bsc_pkg::REG_SEA_OFS: sea_ofs = val[15:0];
        default: ;
      endcase
      @(posedge clk);
    end
  endtask

  // Typical datasheet-like calibration set
  task automatic load_typical_cal(input logic [1:0] os, input logic [15:0] ofs);
    begin
      write_reg(bsc_pkg::REG_CAL_A, {16'd0, 16'sd408, -16'sd72, -16'sd14383});
      write_reg(bsc_pkg::REG_CAL_B, {16'd0, 16'd32741, 16'd32757, 16'd23153});
      write_reg(bsc_pkg::REG_CAL_C, {16'sd6190, 16'sd4, -16'sd8711, 16'sd2868});
      write_reg(bsc_pkg::REG_OSS, {62'd0, os});
      write_reg(bsc_pkg::REG_SEA_OFS, {48'd0, ofs});
    end
  endtask

  // All calibration zero right after reset: both divisors vanish.
  task automatic test_reset_defaults();
    begin
      send_raw(16'd0, 19'd0, 1'b0);
      send_raw(16'hffff, 19'h7ffff, 1'b0);
      send_raw(16'd27898, 19'd23843, 1'b0);
      drain();
    end
  endtask

  // Field extremes, a realistic point, and both quotient branches.
  task automatic test_directed();
    begin
      load_typical_cal(2'd0, 16'd8400);
      send_raw(16'd27898, 19'd23843, 1'b0);
      send_raw(16'd0, 19'd0, 1'b0);
      send_raw(16'hffff, 19'h7ffff, 1'b0);
      send_raw(16'hffff, 19'd0, 1'b0);
      send_raw(16'd0, 19'h7ffff, 1'b0);
      send_raw(16'h5555, 19'h2aaaa, 1'b0);
      send_raw(16'haaaa, 19'h55555, 1'b0);
      drain();
      // Temperature divisor zero: ac5=0 makes x1=0, md=0
      write_reg(bsc_pkg::REG_CAL_B, {16'd0, 16'd32741, 16'd0, 16'd23153});
      write_reg(bsc_pkg::REG_CAL_C, {16'sd6190, 16'sd4, -16'sd8711, 16'sd0});
      send_raw(16'd1000, 19'd5000, 1'b0);
      drain();
      // Pressure divisor zero: ac4=0
      write_reg(bsc_pkg::REG_CAL_B, {16'd0, 16'd0, 16'd32757, 16'd23153});
      send_raw(16'd27898, 19'd23843, 1'b0);
      drain();
      // Extreme coefficients, max oss and offset: saturation and wrap
      write_reg(bsc_pkg::REG_CAL_A, {16'd0, 16'h7fff, 16'h8000, 16'h7fff});
      write_reg(bsc_pkg::REG_CAL_B, {16'd0, 16'hffff, 16'hffff, 16'h0000});
      write_reg(bsc_pkg::REG_CAL_C, {16'h8000, 16'h7fff, 16'h7fff, 16'h0001});
      write_reg(bsc_pkg::REG_OSS, 64'd3);
      write_reg(bsc_pkg::REG_SEA_OFS, 64'hffff);
      send_raw(16'hffff, 19'h7ffff, 1'b0);
      send_raw(16'd0, 19'd0, 1'b0);
      send_raw(16'h8000, 19'h40000, 1'b0);
      drain();
      write_reg(bsc_pkg::REG_CAL_A, {16'd0, 16'h8000, 16'h7fff, 16'h8000});
      write_reg(bsc_pkg::REG_CAL_B, {16'd0, 16'h0001, 16'h0000, 16'hffff});
      write_reg(bsc_pkg::REG_CAL_C, {16'h7fff, 16'h8000, 16'h8000, 16'hffff});
      write_reg(bsc_pkg::REG_SEA_OFS, 64'd0);
      send_raw(16'hffff, 19'h7ffff, 1'b0);
      send_raw(16'd0, 19'd1, 1'b0);
      drain();
    end
  endtask

  // Random raw items over several settings; one phase back-to-back.
  task automatic test_random(input int phase, input int count, input bit full_rate);
    begin
      if (phase % 3 == 0) begin
        load_typical_cal(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)));
      end else begin
        write_reg(bsc_pkg::REG_CAL_A, {$urandom, $urandom});
        write_reg(bsc_pkg::REG_CAL_B, {$urandom, $urandom});
        write_reg(bsc_pkg::REG_CAL_C, {$urandom, $urandom});
        write_reg(bsc_pkg::REG_OSS, 64'($urandom_range(0, 3)));
        write_reg(bsc_pkg::REG_SEA_OFS, 64'($urandom_range(0, 65535)));
      end
      rx_quiet = full_rate;
      repeat (count) begin
        if (phase % 3 == 0 && $urandom_range(0, 3) != 0)
          send_raw(16'($urandom_range(20000, 35000)),
                   19'($urandom_range(0, 524287) >> 2), !full_rate);
        else
          send_raw(16'($urandom_range(0, 65535)), 19'($urandom_range(0, 524287)),
                   !full_rate);
      end
      drain();
      rx_quiet = 0;
    end
  endtask

  initial begin
    cal_a = '0; cal_b = '0; cal_c = '0;
    oss = bsc_pkg::OSS_RST; sea_ofs = bsc_pkg::SEA_RST;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_addr = bsc_pkg::REG_CAL_A;
    cfg_wdata = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    for (int ph = 0; ph < 8; ph++) test_random(ph, 160, ph == 4);
    $display("Covered %0d items, %0d results checked, %0d with divide fault.",
             n_sent, n_checked, n_faults);
    $display("Settings: reset values, extremes, datasheet-like and random calibrations.");
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
